// ===== src/fault_event_store_macros.svh =====
// Assertion macros used by fes_engine of the fault event store RTL.
// Taken in by `include; compiled out when SYNTH is defined.
`ifndef FAULT_EVENT_STORE_MACROS_SVH
`define FAULT_EVENT_STORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FES_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FES_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/fes_pkg.sv =====
// Types, codes and helper functions of the fault event store.
// No dependencies; used by every module of the block.
package fes_pkg;

   localparam int SEV_W     = 3;
   localparam int KEY_W     = 35;
   localparam int TIME_W    = 32;
   localparam int KEEP_W    = 16;
   localparam int NUM_KEEP  = 5;
   localparam int CSR_IDX_W = 3;
   localparam int OUT_CNT_W = 8;

   // op codes
   localparam logic [2:0] OP_SET    = 3'd0;
   localparam logic [2:0] OP_GET    = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_COUNT  = 3'd3;
   localparam logic [2:0] OP_AGE    = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // status codes
   localparam logic [2:0] STAT_ADDED     = 3'd0;
   localparam logic [2:0] STAT_REFRESHED = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_FOUND     = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [2:0] STAT_DONE      = 3'd5;

   // severity levels
   localparam logic [SEV_W-1:0] SEV_INFO = 3'd0;
   localparam logic [SEV_W-1:0] SEV_LOW  = 3'd1;
   localparam logic [SEV_W-1:0] SEV_MID  = 3'd2;
   localparam logic [SEV_W-1:0] SEV_HIGH = 3'd3;
   localparam logic [SEV_W-1:0] SEV_CRIT = 3'd4;

   // retention thresholds after reset, listed critical first; index 0 is info
   localparam logic [NUM_KEEP-1:0][KEEP_W-1:0] KEEP_RESET =
      {16'd15, 16'd10, 16'd8, 16'd5, 16'd3};

   typedef struct packed {
      logic [2:0]        op;
      logic [15:0]       module_id;
      logic [15:0]       error_code;
      logic [SEV_W-1:0]  severity;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [SEV_W-1:0]     found_severity;
      logic [OUT_CNT_W-1:0] entry_count;
      logic [OUT_CNT_W-1:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   function automatic logic [SEV_W-1:0] sat_sev(input logic [SEV_W-1:0] s);
      return (s > SEV_CRIT) ? SEV_CRIT : s;
   endfunction

   function automatic logic [KEY_W-1:0] make_key(input logic [15:0] mod,
                                                 input logic [15:0] code,
                                                 input logic [SEV_W-1:0] sev);
      return {mod, code, sat_sev(sev)};
   endfunction

endpackage

// ===== src/fault_event_store.sv =====
// Top level of the fault event store.
// Depends on fes_pkg, fes_keep_regs and fes_engine.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. req_data carries op, module_id, error_code, severity and now_ms.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_data
//   (status, found_severity, entry_count, removed_count). One result per item.
//   The receiver cannot stall; each result must be captured in its strobe cycle.
//   CSR port: csr_write_en writes csr_wdata into the retention threshold picked
//   by csr_index (0 info .. 4 critical); write only while busy is low.
// Operation flow:
//   count, clear and unused ops: result registered in the cycle after start, busy
//   stays low, so a new item may follow in the very next cycle.
//   set/get: a scan reads the entries one by one through the single-port entry
//   memory (issue read, then compare); rsp_strobe rises in the same cycle that
//   busy falls.
//   remove/age: the same scan, plus a move of the last entry into the slot of
//   each deleted entry that is not the last (memory read, then write-back).
// Reset: synchronous; clears entry count, start counter and restores the
// default thresholds. Entry memory contents are not cleared.
module fault_event_store import fes_pkg::*; #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEEP_W-1:0]    csr_wdata
);

   // severity of the entry under test and its retention threshold
   logic [SEV_W-1:0]  sev_sel;
   logic [KEEP_W-1:0] threshold;

   fes_keep_regs u_keep (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sev_sel      (sev_sel),
      .threshold    (threshold)
   );

   // scan sequencer with the entry memory; start is ignored while busy
   fes_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start & ~busy),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .sev_sel    (sev_sel),
      .threshold  (threshold)
   );

endmodule

// ===== src/fes_keep_regs.sv =====
// Retention threshold registers of the fault event store.
// Depends on fes_pkg; written through the csr port, read by severity.
module fes_keep_regs import fes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEEP_W-1:0]    csr_wdata,
   input  logic [SEV_W-1:0]     sev_sel,
   output logic [KEEP_W-1:0]    threshold
);

   logic [NUM_KEEP-1:0][KEEP_W-1:0] keep_ff, keep_in;

   always_comb begin
      keep_in = keep_ff;
      for (int i = 0; i < NUM_KEEP; i++) begin
         if (csr_write_en && csr_index == CSR_IDX_W'(i)) begin
            keep_in[i] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
      end else begin
         keep_ff <= keep_in;
      end
   end

   // sev_sel is already saturated; anything above critical reads critical
   always_comb begin
      case (sev_sel)
         SEV_INFO: threshold = keep_ff[0];
         SEV_LOW:  threshold = keep_ff[1];
         SEV_MID:  threshold = keep_ff[2];
         SEV_HIGH: threshold = keep_ff[3];
         default:  threshold = keep_ff[4];
      endcase
   end

endmodule

// ===== src/fes_engine.sv =====
// Entry memory and scan sequencer of the fault event store.
// Depends on fes_pkg and fault_event_store_macros.svh.
`include "fault_event_store_macros.svh"
module fes_engine import fes_pkg::*; #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   output logic [SEV_W-1:0]  sev_sel,
   input  logic [KEEP_W-1:0] threshold
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_MOVE  = 3'd4;

   entry_type entry_mem [TABLE_DEPTH];
   entry_type rdata_ff;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  removed_ff, removed_in;
   logic [KEEP_W-1:0] starts_ff, starts_in;
   logic [2:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   entry_type         mem_wdata;
   logic              finish;
   logic [2:0]        fin_status;
   logic [SEV_W-1:0]  fin_sev;
   logic [SEV_W-1:0]  rd_sev;
   logic              kill;

   assign rd_sev  = sat_sev(rdata_ff.key[SEV_W-1:0]);
   assign sev_sel = rd_sev;
   assign kill    = (op_ff == OP_AGE) ? (starts_ff >= threshold)
                                      : (rd_sev <= key_ff[SEV_W-1:0]);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      starts_in    = starts_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      time_in      = time_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_raddr    = idx_ff[AW-1:0];
      mem_wdata    = '{key: key_ff, stamp: time_ff};
      finish       = 1'b0;
      fin_status   = STAT_DONE;
      fin_sev      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_data.op;
               key_in     = make_key(req_data.module_id, req_data.error_code,
                                     req_data.severity);
               time_in    = req_data.now_ms;
               idx_in     = '0;
               removed_in = '0;
               case (req_data.op)
                  OP_SET, OP_GET, OP_REMOVE, OP_AGE: begin
                     state_in = S_READ;
                  end
                  OP_COUNT: begin
                     if (starts_ff != '1) begin
                        starts_in = starts_ff + KEEP_W'(1);
                     end
                     finish = 1'b1;
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     starts_in = '0;
                     finish    = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            if (idx_ff == count_ff) begin
               // scan ran off the end of the valid entries
               finish   = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  OP_SET: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_ff[AW-1:0];
                        count_in   = count_ff + CNT_W'(1);
                        fin_status = STAT_ADDED;
                     end else begin
                        fin_status = STAT_FULL;
                     end
                  end
                  OP_GET: begin
                     fin_status = STAT_NOT_FOUND;
                  end
                  default: begin
                     fin_status = STAT_DONE;
                  end
               endcase
            end else begin
               mem_re   = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (op_ff)
               OP_SET: begin
                  if (rdata_ff.key == key_ff) begin
                     mem_we     = 1'b1;
                     finish     = 1'b1;
                     fin_status = STAT_REFRESHED;
                     state_in   = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_READ;
                  end
               end
               OP_GET: begin
                  if (rdata_ff.key[KEY_W-1:SEV_W] == key_ff[KEY_W-1:SEV_W]) begin
                     finish     = 1'b1;
                     fin_status = STAT_FOUND;
                     fin_sev    = rd_sev;
                     state_in   = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_READ;
                  end
               end
               default: begin
                  if (kill) begin
                     removed_in = removed_ff + CNT_W'(1);
                     count_in   = count_ff - CNT_W'(1);
                     // deleting the last entry needs no move
                     state_in   = (idx_ff == count_ff - CNT_W'(1)) ? S_READ : S_LAST;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_LAST: begin
            // count already decremented: it now points at the old last entry
            mem_re    = 1'b1;
            mem_raddr = count_ff[AW-1:0];
            state_in  = S_MOVE;
         end
         S_MOVE: begin
            // fill the hole, then re-examine the same slot
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
            state_in  = S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{status:         fin_status,
                    found_severity: fin_sev,
                    entry_count:    OUT_CNT_W'(count_in),
                    removed_count:  OUT_CNT_W'(removed_in)};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entry_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         starts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         starts_ff    <= starts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      removed_ff <= removed_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      time_ff    <= time_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `FES_ASSERT_IMPL(a_idx_in_range, clock, reset, state_ff != S_IDLE, idx_ff <= count_ff, "scan index past valid entries")
   `FES_ASSERT_IMPL(a_one_port_op, clock, reset, mem_we, !mem_re, "memory read and write in the same cycle")
   `FES_ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_valid_ff && (rsp_ff.status == STAT_ADDED || rsp_ff.status == STAT_REFRESHED || rsp_ff.status == STAT_FOUND), count_ff != '0, "hit reported on empty table")
   `FES_ASSERT_NEXT(a_move_after_last, clock, reset, state_ff == S_LAST, mem_we && mem_waddr == $past(idx_ff[AW-1:0]), "moved entry not written to hole")

endmodule
